### rtl/arm_inverse_kinematics_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the arm inverse kinematics core
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ARM_INVERSE_KINEMATICS_CORE_MACROS_SVH
`define ARM_INVERSE_KINEMATICS_CORE_MACROS_SVH

// same-cycle implication
`define AIK_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aik: same-cycle check failed");

// next-cycle implication
`define AIK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aik: next-cycle check failed");

`endif

### rtl/aik_pkg.sv
// ----------------------------------------------------------------------------
// aik_pkg
// Widths, constants, item types and helper functions of the IK core.
// ----------------------------------------------------------------------------
package aik_pkg;

    localparam int POS_W        = 18;
    localparam int MODE_W       = 2;
    localparam int LEN_W        = 16;
    localparam int ANG_OUT_W    = 17;
    localparam int CFG_IDX_W    = 2;
    localparam int VEC_W        = 38;
    localparam int ACC_W        = 27;
    localparam int ANG_W        = 30;
    localparam int SQ_W         = 64;
    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 5;
    localparam int LANES        = 4;

    // lane order in the CORDIC chain
    localparam int LANE_BASE  = 0;
    localparam int LANE_ALPHA = 1;
    localparam int LANE_GAMMA = 2;
    localparam int LANE_BETA  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd1;

    // gripper poses
    localparam logic [MODE_W-1:0] GRIP_DOWN  = 2'd1;
    localparam logic [MODE_W-1:0] GRIP_LEVEL = 2'd2;

    localparam logic [LEN_W-1:0] UPPER_RESET = 16'd13763;
    localparam logic [LEN_W-1:0] LOWER_RESET = 16'd15073;

    // angles in units of 2^-16 degree
    localparam logic signed [ANG_W-1:0] DEG90      = 30'sd5898240;
    localparam logic signed [ANG_W-1:0] DEG180     = 30'sd11796480;
    localparam logic signed [ACC_W-1:0] ACC_DEG180 = 27'sd11796480;
    localparam logic signed [ANG_W-1:0] ROUND_HALF = 30'sd256;
    localparam logic signed [ANG_W-1:0] LIMIT_W    = 30'sd46080;
    localparam logic signed [ANG_OUT_W-1:0] OUT_LIMIT = 17'sd46080;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [MODE_W-1:0]       mode;
        logic                    oor;
        logic signed [VEC_W-1:0] gdot;
        logic signed [VEC_W-1:0] bdot;
    } side_t;

    typedef struct packed {
        logic [SQ_W-1:0] p_rem;
        logic [SQ_W-1:0] p_res;
        logic [SQ_W-1:0] h_rem;
        logic [SQ_W-1:0] h_res;
        side_t           side;
    } sq_item_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] cx;
        logic signed [VEC_W-1:0] cy;
        logic signed [ACC_W-1:0] acc;
        logic                    zero;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0] lane;
        logic [MODE_W-1:0] mode;
        logic              oor;
    } cd_item_t;

    // atan(2^-i) in units of 2^-16 degree
    function automatic logic signed [ACC_W-1:0] atan_of(input logic [STEP_W-1:0] i);
        logic signed [ACC_W-1:0] a;
        case (i)
            5'd0:    a = 27'sd2949120;
            5'd1:    a = 27'sd1740967;
            5'd2:    a = 27'sd919879;
            5'd3:    a = 27'sd466945;
            5'd4:    a = 27'sd234379;
            5'd5:    a = 27'sd117304;
            5'd6:    a = 27'sd58666;
            5'd7:    a = 27'sd29335;
            5'd8:    a = 27'sd14668;
            5'd9:    a = 27'sd7334;
            5'd10:   a = 27'sd3667;
            5'd11:   a = 27'sd1833;
            5'd12:   a = 27'sd917;
            5'd13:   a = 27'sd458;
            5'd14:   a = 27'sd229;
            5'd15:   a = 27'sd115;
            5'd16:   a = 27'sd57;
            5'd17:   a = 27'sd29;
            5'd18:   a = 27'sd14;
            5'd19:   a = 27'sd7;
            5'd20:   a = 27'sd4;
            5'd21:   a = 27'sd2;
            5'd22:   a = 27'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

    // fold into the right half-plane before vectoring
    function automatic lane_t lane_init(input logic signed [VEC_W-1:0] ny,
                                        input logic signed [VEC_W-1:0] nx);
        lane_t l;
        l.zero = (nx == '0) && (ny == '0);
        if (nx < 0)
        begin
            l.cx  = -nx;
            l.cy  = -ny;
            l.acc = (ny >= 0) ? ACC_DEG180 : -ACC_DEG180;
        end
        else
        begin
            l.cx  = nx;
            l.cy  = ny;
            l.acc = '0;
        end
        return l;
    endfunction

    // round to 1/128 degree and saturate
    function automatic logic signed [ANG_OUT_W-1:0] to_out(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W-1:0] sh;
        logic signed [ANG_OUT_W-1:0] r;
        sh = (v + ROUND_HALF) >>> 9;
        if (sh > LIMIT_W)
            r = OUT_LIMIT;
        else if (sh < -LIMIT_W)
            r = -OUT_LIMIT;
        else
            r = sh[ANG_OUT_W-1:0];
        return r;
    endfunction

endpackage

### rtl/aik_if.sv
// ----------------------------------------------------------------------------
// aik interfaces
// Target, joint result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface aik_target_if;
    import aik_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;
    logic signed [POS_W-1:0] target_z;
    logic [MODE_W-1:0]       gripper_mode;

    modport source (output valid, target_x, target_y, target_z, gripper_mode,
                    input ready);
    modport sink   (input valid, target_x, target_y, target_z, gripper_mode,
                    output ready);
endinterface

interface aik_joints_if;
    import aik_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [ANG_OUT_W-1:0] base_angle;
    logic signed [ANG_OUT_W-1:0] shoulder_angle;
    logic signed [ANG_OUT_W-1:0] elbow_angle;
    logic signed [ANG_OUT_W-1:0] wrist_pitch;
    logic signed [ANG_OUT_W-1:0] wrist_rotate;
    logic                        wrist_valid;
    logic                        out_of_reach;

    modport source (output valid, base_angle, shoulder_angle, elbow_angle, wrist_pitch,
                    wrist_rotate, wrist_valid, out_of_reach, input ready);
    modport sink   (input valid, base_angle, shoulder_angle, elbow_angle, wrist_pitch,
                    wrist_rotate, wrist_valid, out_of_reach, output ready);
endinterface

interface aik_cfg_if;
    import aik_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [LEN_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/arm_inverse_kinematics_core.sv
// Throughput: one request per cycle while the joint receiver is ready; the chain
// of 32 root cells and 16 CORDIC cells is fully pipelined, and each stage holds
// its item while stalled.
// Reset: rst_n clears all stage valid flags and loads the link lengths with
// 13763 and 15073 (0.21 m and 0.23 m).
// ----------------------------------------------------------------------------
// arm_inverse_kinematics_core
// Two-link arm inverse kinematics with base yaw: front end, root cell chain,
// CORDIC cell chain and joint angle assembly.
// ----------------------------------------------------------------------------
`include "arm_inverse_kinematics_core_macros.svh"

module arm_inverse_kinematics_core (
    input  logic         clk,
    input  logic         rst_n,
    aik_target_if.sink   target,
    aik_joints_if.source joints,
    aik_cfg_if.sink      cfg
);
    import aik_pkg::*;

    logic [LEN_W-1:0] l1_reg, l2_reg;

    logic     sq_v [SQRT_STEPS+1];
    logic     sq_r [SQRT_STEPS+1];
    sq_item_t sq_d [SQRT_STEPS+1];
    logic     cd_v [CORDIC_STEPS+1];
    logic     cd_r [CORDIC_STEPS+1];
    cd_item_t cd_d [CORDIC_STEPS+1];

    logic     vp_reg, vb1_reg, vb2_reg;
    logic     en_b1, en_b2;
    cd_item_t prep_reg, prep_next;
    sq_item_t sq_last;
    cd_item_t cd_last;

    logic signed [ANG_W-1:0] base_next, alpha_a, gamma_a, beta_a, shoulder_next, m2_next;
    logic signed [ANG_W-1:0] base_reg, shoulder_reg, m2_reg;
    logic [MODE_W-1:0]       mode_reg;
    logic                    oor_reg;

    logic signed [ANG_OUT_W-1:0] base_o_reg, shoulder_o_reg, elbow_o_reg;
    logic signed [ANG_OUT_W-1:0] pitch_o_reg, rotate_o_reg;
    logic                        wv_o_reg, oor_o_reg;
    logic signed [ANG_OUT_W-1:0] base_o, shoulder_o, elbow_o, pitch_o, rotate_o;
    logic                        wv_o;

    // link length registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_reg <= UPPER_RESET;
            l2_reg <= LOWER_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_UPPER: l1_reg <= cfg.data;
                REG_LOWER: l2_reg <= cfg.data;
                default:   ;
            endcase
        end
    end

    // front end
    aik_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .target    (target),
        .l1        (l1_reg),
        .l2        (l2_reg),
        .out_valid (sq_v[0]),
        .out_ready (sq_r[0]),
        .out_item  (sq_d[0])
    );

    // square root cell chain, one digit per cell
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        aik_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (STEP_W'(k)),
            .in_valid  (sq_v[k]),
            .in_ready  (sq_r[k]),
            .in_item   (sq_d[k]),
            .out_valid (sq_v[k+1]),
            .out_ready (sq_r[k+1]),
            .out_item  (sq_d[k+1])
        );
    end

    // CORDIC lane set-up
    assign sq_last = sq_d[SQRT_STEPS];
    assign sq_r[SQRT_STEPS] = !vp_reg || cd_r[0];

    always_comb
    begin
        prep_next.lane[LANE_BASE]  = lane_init(VEC_W'(sq_last.side.x), VEC_W'(sq_last.side.y));
        prep_next.lane[LANE_ALPHA] = lane_init(VEC_W'(sq_last.side.z) <<< 4,
                                               $signed({16'b0, sq_last.h_res[21:0]}));
        prep_next.lane[LANE_GAMMA] = lane_init($signed({4'b0, sq_last.p_res[31:0], 2'b00}),
                                               sq_last.side.gdot);
        prep_next.lane[LANE_BETA]  = lane_init($signed({4'b0, sq_last.p_res[31:0], 2'b00}),
                                               sq_last.side.bdot);
        prep_next.mode = sq_last.side.mode;
        prep_next.oor  = sq_last.side.oor;
    end

    assign cd_v[0] = vp_reg;
    assign cd_d[0] = prep_reg;

    // CORDIC cell chain
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        aik_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (STEP_W'(k)),
            .in_valid  (cd_v[k]),
            .in_ready  (cd_r[k]),
            .in_item   (cd_d[k]),
            .out_valid (cd_v[k+1]),
            .out_ready (cd_r[k+1]),
            .out_item  (cd_d[k+1])
        );
    end

    // joint sums
    assign cd_last = cd_d[CORDIC_STEPS];
    assign en_b2   = !vb2_reg || joints.ready;
    assign en_b1   = !vb1_reg || en_b2;
    assign cd_r[CORDIC_STEPS] = en_b1;

    assign base_next  = cd_last.lane[LANE_BASE].zero  ? '0 :
                        ANG_W'(cd_last.lane[LANE_BASE].acc);
    assign alpha_a    = cd_last.lane[LANE_ALPHA].zero ? '0 :
                        ANG_W'(cd_last.lane[LANE_ALPHA].acc);
    assign gamma_a    = cd_last.lane[LANE_GAMMA].zero ? '0 :
                        ANG_W'(cd_last.lane[LANE_GAMMA].acc);
    assign beta_a     = cd_last.lane[LANE_BETA].zero  ? '0 :
                        ANG_W'(cd_last.lane[LANE_BETA].acc);
    assign shoulder_next = DEG90 - alpha_a - beta_a;
    assign m2_next       = DEG180 - gamma_a - alpha_a - beta_a;

    // output rounding and pose selection
    always_comb
    begin
        base_o     = to_out(base_reg);
        shoulder_o = to_out(shoulder_reg);
        elbow_o    = to_out(-m2_reg);
        case (mode_reg)
            GRIP_DOWN:
            begin
                pitch_o  = to_out(m2_reg - DEG90);
                rotate_o = base_o;
                wv_o     = 1'b1;
            end
            GRIP_LEVEL:
            begin
                pitch_o  = to_out(m2_reg);
                rotate_o = '0;
                wv_o     = 1'b1;
            end
            default:
            begin
                pitch_o  = '0;
                rotate_o = '0;
                wv_o     = 1'b0;
            end
        endcase
        if (oor_reg)
        begin
            base_o     = '0;
            shoulder_o = '0;
            elbow_o    = '0;
            pitch_o    = '0;
            rotate_o   = '0;
            wv_o       = 1'b0;
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg  <= 1'b0;
            vb1_reg <= 1'b0;
            vb2_reg <= 1'b0;
        end
        else
        begin
            if (sq_r[SQRT_STEPS]) vp_reg  <= sq_v[SQRT_STEPS];
            if (en_b1)            vb1_reg <= cd_v[CORDIC_STEPS];
            if (en_b2)            vb2_reg <= vb1_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (sq_r[SQRT_STEPS] && sq_v[SQRT_STEPS])
            prep_reg <= prep_next;
        if (en_b1 && cd_v[CORDIC_STEPS])
        begin
            base_reg     <= base_next;
            shoulder_reg <= shoulder_next;
            m2_reg       <= m2_next;
            mode_reg     <= cd_last.mode;
            oor_reg      <= cd_last.oor;
        end
        if (en_b2 && vb1_reg)
        begin
            base_o_reg     <= base_o;
            shoulder_o_reg <= shoulder_o;
            elbow_o_reg    <= elbow_o;
            pitch_o_reg    <= pitch_o;
            rotate_o_reg   <= rotate_o;
            wv_o_reg       <= wv_o;
            oor_o_reg      <= oor_reg;
        end
    end

    assign joints.valid          = vb2_reg;
    assign joints.base_angle     = base_o_reg;
    assign joints.shoulder_angle = shoulder_o_reg;
    assign joints.elbow_angle    = elbow_o_reg;
    assign joints.wrist_pitch    = pitch_o_reg;
    assign joints.wrist_rotate   = rotate_o_reg;
    assign joints.wrist_valid    = wv_o_reg;
    assign joints.out_of_reach   = oor_o_reg;

    // checks
    `AIK_IMPLY(a_reach_zero, joints.valid && joints.out_of_reach, joints.base_angle == '0 && joints.shoulder_angle == '0 && !joints.wrist_valid)
    `AIK_IMPLY(a_wrist_zero, joints.valid && !joints.wrist_valid, joints.wrist_pitch == '0 && joints.wrist_rotate == '0)
    `AIK_IMPLY(a_elbow_sat, joints.valid, joints.elbow_angle <= OUT_LIMIT && joints.elbow_angle >= -OUT_LIMIT)
    `AIK_NEXT(a_cfg_upper, cfg.valid && cfg.index == REG_UPPER, l1_reg == $past(cfg.data))

endmodule

### rtl/aik_front.sv
// ----------------------------------------------------------------------------
// aik_front
// Five-stage front end: squares, reach sums, law-of-cosines terms, area product.
// ----------------------------------------------------------------------------
module aik_front (
    input  logic             clk,
    input  logic             rst_n,
    aik_target_if.sink       target,
    input  logic [15:0]      l1,
    input  logic [15:0]      l2,
    output logic             out_valid,
    input  logic             out_ready,
    output aik_pkg::sq_item_t out_item
);
    import aik_pkg::*;

    logic en1, en2, en3, en4, en5;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    side_t s1_reg, s2_reg, s3_reg, s4_reg;
    logic [35:0] xx1_reg, yy1_reg, zz1_reg, zz2_reg;
    logic [31:0] l1sq1_reg, l2sq1_reg, dd1_reg;
    logic [31:0] l1sq2_reg, l2sq2_reg, dd2_reg;
    logic [31:0] l1sq3_reg, l2sq3_reg, dd3_reg;
    logic [33:0] ss1_reg, ss2_reg, ss3_reg;
    logic [35:0] h2_2_reg, h2_3_reg, h2_4_reg, a2_3_reg;
    logic [31:0] pq4_reg, pr4_reg;
    sq_item_t    item_reg;

    logic signed [35:0] xx_next, yy_next, zz_next;
    logic [31:0]        l1sq_next, l2sq_next;
    logic signed [16:0] dl;
    logic signed [33:0] dd_next;
    logic [16:0]        sl;
    logic [33:0]        ss_next;
    logic signed [VEC_W-1:0] q_next, r_next, gdot_next, bdot_next;
    side_t              s1_next, s4_next;
    sq_item_t           item_next;

    // backpressure ripples from the output towards the input
    assign en5 = !v5_reg || out_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign target.ready = en1;
    assign out_valid = v5_reg;
    assign out_item  = item_reg;

    // stage 1: squares
    assign xx_next   = target.target_x * target.target_x;
    assign yy_next   = target.target_y * target.target_y;
    assign zz_next   = target.target_z * target.target_z;
    assign l1sq_next = l1 * l1;
    assign l2sq_next = l2 * l2;
    assign dl        = $signed({1'b0, l1}) - $signed({1'b0, l2});
    assign dd_next   = dl * dl;
    assign sl        = {1'b0, l1} + {1'b0, l2};
    assign ss_next   = sl * sl;

    always_comb
    begin
        s1_next      = '0;
        s1_next.x    = target.target_x;
        s1_next.y    = target.target_y;
        s1_next.z    = target.target_z;
        s1_next.mode = target.gripper_mode;
    end

    // stage 4: reach tests and dot terms
    assign q_next    = $signed({2'b0, a2_3_reg}) - $signed({6'b0, dd3_reg});
    assign r_next    = $signed({4'b0, ss3_reg}) - $signed({2'b0, a2_3_reg});
    assign gdot_next = $signed({6'b0, l1sq3_reg}) + $signed({6'b0, l2sq3_reg})
                     - $signed({2'b0, a2_3_reg});
    assign bdot_next = $signed({6'b0, l1sq3_reg}) + $signed({2'b0, a2_3_reg})
                     - $signed({6'b0, l2sq3_reg});

    always_comb
    begin
        s4_next      = s3_reg;
        s4_next.gdot = gdot_next;
        s4_next.bdot = bdot_next;
        s4_next.oor  = (a2_3_reg == '0) || (q_next < 0) || (r_next < 0);
    end

    // stage 5: area product and square root seeds
    always_comb
    begin
        item_next       = '0;
        item_next.p_rem = pq4_reg * pr4_reg;
        item_next.h_rem = {20'b0, h2_4_reg, 8'b0};
        item_next.side  = s4_reg;
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= target.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (en1 && target.valid)
        begin
            s1_reg    <= s1_next;
            xx1_reg   <= xx_next;
            yy1_reg   <= yy_next;
            zz1_reg   <= zz_next;
            l1sq1_reg <= l1sq_next;
            l2sq1_reg <= l2sq_next;
            dd1_reg   <= dd_next[31:0];
            ss1_reg   <= ss_next;
        end
        if (en2 && v1_reg)
        begin
            s2_reg    <= s1_reg;
            h2_2_reg  <= xx1_reg + yy1_reg;
            zz2_reg   <= zz1_reg;
            l1sq2_reg <= l1sq1_reg;
            l2sq2_reg <= l2sq1_reg;
            dd2_reg   <= dd1_reg;
            ss2_reg   <= ss1_reg;
        end
        if (en3 && v2_reg)
        begin
            s3_reg    <= s2_reg;
            a2_3_reg  <= h2_2_reg + zz2_reg;
            h2_3_reg  <= h2_2_reg;
            l1sq3_reg <= l1sq2_reg;
            l2sq3_reg <= l2sq2_reg;
            dd3_reg   <= dd2_reg;
            ss3_reg   <= ss2_reg;
        end
        if (en4 && v3_reg)
        begin
            s4_reg   <= s4_next;
            pq4_reg  <= q_next[33:2];
            pr4_reg  <= r_next[33:2];
            h2_4_reg <= h2_3_reg;
        end
        if (en5 && v4_reg)
            item_reg <= item_next;
    end

endmodule

### rtl/aik_sqrt_cell.sv
// ----------------------------------------------------------------------------
// aik_sqrt_cell
// One digit of two integer square roots (area and horizontal reach).
// ----------------------------------------------------------------------------
module aik_sqrt_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [aik_pkg::STEP_W-1:0] step,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  aik_pkg::sq_item_t          in_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output aik_pkg::sq_item_t          out_item
);
    import aik_pkg::*;

    logic            vld_reg;
    sq_item_t        item_reg;
    sq_item_t        item_next;
    logic [5:0]      sh;
    logic [SQ_W-1:0] bit_v, sum_p, sum_h;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_item  = item_reg;

    // trial bit for this digit
    assign sh    = 6'd62 - {step, 1'b0};
    assign bit_v = {{(SQ_W-1){1'b0}}, 1'b1} << sh;
    assign sum_p = in_item.p_res + bit_v;
    assign sum_h = in_item.h_res + bit_v;

    // restoring digit step, both roots side by side
    always_comb
    begin
        item_next = in_item;
        if (in_item.p_rem >= sum_p)
        begin
            item_next.p_rem = in_item.p_rem - sum_p;
            item_next.p_res = (in_item.p_res >> 1) + bit_v;
        end
        else
            item_next.p_res = in_item.p_res >> 1;
        if (in_item.h_rem >= sum_h)
        begin
            item_next.h_rem = in_item.h_rem - sum_h;
            item_next.h_res = (in_item.h_res >> 1) + bit_v;
        end
        else
            item_next.h_res = in_item.h_res >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

endmodule

### rtl/aik_cordic_cell.sv
// ----------------------------------------------------------------------------
// aik_cordic_cell
// One vectoring CORDIC iteration on all four angle lanes.
// ----------------------------------------------------------------------------
module aik_cordic_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [aik_pkg::STEP_W-1:0] step,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  aik_pkg::cd_item_t          in_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output aik_pkg::cd_item_t          out_item
);
    import aik_pkg::*;

    logic                    vld_reg;
    cd_item_t                item_reg;
    cd_item_t                item_next;
    logic signed [ACC_W-1:0] ang;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_item  = item_reg;
    assign ang       = atan_of(step);

    // rotate each lane towards the x axis
    always_comb
    begin
        item_next = in_item;
        for (int i = 0; i < LANES; i++)
        begin
            if (in_item.lane[i].cy > 0)
            begin
                item_next.lane[i].cx  = in_item.lane[i].cx + (in_item.lane[i].cy >>> step);
                item_next.lane[i].cy  = in_item.lane[i].cy - (in_item.lane[i].cx >>> step);
                item_next.lane[i].acc = in_item.lane[i].acc + ang;
            end
            else
            begin
                item_next.lane[i].cx  = in_item.lane[i].cx - (in_item.lane[i].cy >>> step);
                item_next.lane[i].cy  = in_item.lane[i].cy + (in_item.lane[i].cx >>> step);
                item_next.lane[i].acc = in_item.lane[i].acc - ang;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

endmodule

### test/arm_inverse_kinematics_core_tb.sv
// ----------------------------------------------------------------------------
// arm_inverse_kinematics_core_tb
// Drives target requests in random bursts against a stalling joint receiver,
// predicts every joint result with an integer copy of the arithmetic and
// compares it field by field. Link lengths change between phases while idle.
// ----------------------------------------------------------------------------
module arm_inverse_kinematics_core_tb;
    import aik_pkg::*;

    localparam logic [MODE_W-1:0] GRIP_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] GRIP_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int  DRAIN_CYCLES = 64;
    localparam longint ANG90  = 64'sd5898240;
    localparam longint ANG180 = 64'sd11796480;
    localparam longint SAT    = 64'sd46080;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [MODE_W-1:0]       mode;
    } target_t;

    typedef struct packed {
        logic signed [ANG_OUT_W-1:0] base;
        logic signed [ANG_OUT_W-1:0] shoulder;
        logic signed [ANG_OUT_W-1:0] elbow;
        logic signed [ANG_OUT_W-1:0] pitch;
        logic signed [ANG_OUT_W-1:0] rotate;
        logic                        wvalid;
        logic                        oor;
    } joints_t;

    logic clk;
    logic rst_n;

    aik_target_if tgt ();
    aik_joints_if jnt ();
    aik_cfg_if    cfg ();

    arm_inverse_kinematics_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .target (tgt),
        .joints (jnt),
        .cfg    (cfg)
    );

    target_t pending_targets[$];
    joints_t expected_joints[$];
    logic [LEN_W-1:0] upper_len = UPPER_RESET;
    logic [LEN_W-1:0] lower_len = LOWER_RESET;
    int mismatches = 0;
    int burst_left;
    int gap_left;
    int stall_duty;
    int stall_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // arctangent table, units of 2^-16 degree
    function automatic longint atan_step(input int i);
        longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                            57, 29, 14, 7, 4, 2, 1, 0};
        return tab[i];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // vectoring arctangent, atan2(ny, nx)
    function automatic longint vector_angle(input longint ny, input longint nx);
        longint acc;
        longint tx;
        acc = 0;
        if (nx == 0 && ny == 0)
            return 0;
        if (nx < 0)
        begin
            acc = (ny >= 0) ? ANG180 : -ANG180;
            nx  = -nx;
            ny  = -ny;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (ny > 0)
            begin
                tx  = nx + (ny >>> i);
                ny  = ny - (nx >>> i);
                acc = acc + atan_step(i);
            end
            else
            begin
                tx  = nx - (ny >>> i);
                ny  = ny + (nx >>> i);
                acc = acc - atan_step(i);
            end
            nx = tx;
        end
        return acc;
    endfunction

    function automatic logic signed [ANG_OUT_W-1:0] round_angle(input longint v);
        longint r;
        r = (v + 256) >>> 9;
        if (r > SAT)
            r = SAT;
        if (r < -SAT)
            r = -SAT;
        return r[ANG_OUT_W-1:0];
    endfunction

    // joint angles for one target under the current link lengths
    function automatic joints_t solve_joints(input target_t t);
        joints_t j;
        longint x, y, z, l1, l2, h2, a2, d, s, q, r, area;
        longint base, alpha, gamma, beta, shoulder, m2;
        x  = t.x;
        y  = t.y;
        z  = t.z;
        l1 = upper_len;
        l2 = lower_len;
        h2 = x * x + y * y;
        a2 = h2 + z * z;
        d  = l1 - l2;
        s  = l1 + l2;
        q  = a2 - d * d;
        r  = s * s - a2;
        j  = '0;
        if (a2 == 0 || q < 0 || r < 0)
        begin
            j.oor = 1'b1;
            return j;
        end
        area = 4 * longint'(int_sqrt((longint'(q) >> 2) * (longint'(r) >> 2)));
        base     = vector_angle(x, y);
        alpha    = vector_angle(z * 16, longint'(int_sqrt(h2 << 8)));
        gamma    = vector_angle(area, l1 * l1 + l2 * l2 - a2);
        beta     = vector_angle(area, l1 * l1 + a2 - l2 * l2);
        shoulder = ANG90 - alpha - beta;
        m2       = (ANG180 - gamma) - (ANG90 - shoulder);
        j.base     = round_angle(base);
        j.shoulder = round_angle(shoulder);
        j.elbow    = round_angle(-m2);
        if (t.mode == GRIP_DOWN)
        begin
            j.pitch  = round_angle(m2 - ANG90);
            j.rotate = round_angle(base);
            j.wvalid = 1'b1;
        end
        else if (t.mode == GRIP_LEVEL)
        begin
            j.pitch  = round_angle(m2);
            j.wvalid = 1'b1;
        end
        return j;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic int clip18(input longint v);
        if (v > 131071)
            return 131071;
        if (v < -131072)
            return -131072;
        return int'(v);
    endfunction

    function automatic int rand_span(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // random target: mostly inside the reach shell, sometimes anywhere
    function automatic target_t random_target();
        target_t t;
        int lim;
        lim = upper_len + lower_len;
        if (lim < 2)
            lim = 2;
        if ($urandom_range(0, 9) < 8)
        begin
            lim = (lim * 3) / 5;
            t.x = POS_W'(clip18(rand_span(lim)));
            t.y = POS_W'(clip18(rand_span(lim)));
            t.z = POS_W'(clip18(rand_span(lim)));
        end
        else
        begin
            t.x = POS_W'($urandom);
            t.y = POS_W'($urandom);
            t.z = POS_W'($urandom);
        end
        t.mode = MODE_W'($urandom_range(0, 3));
        return t;
    endfunction

    function automatic target_t mk(input int x, input int y, input int z,
                                   input logic [MODE_W-1:0] m);
        target_t t;
        t.x    = POS_W'(x);
        t.y    = POS_W'(y);
        t.z    = POS_W'(z);
        t.mode = m;
        return t;
    endfunction

    // queue one target request for the sender
    task automatic queue_target(input target_t t);
        pending_targets.insert(pending_targets.size(), t);
    endtask

    // target sender: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt.valid        <= 1'b0;
            tgt.target_x     <= '0;
            tgt.target_y     <= '0;
            tgt.target_z     <= '0;
            tgt.gripper_mode <= '0;
            burst_left       <= 1;
            gap_left         <= 0;
        end
        else if (!tgt.valid || tgt.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left  <= gap_left - 1;
                tgt.valid <= 1'b0;
            end
            else if (pending_targets.size() > 0)
            begin
                target_t t;
                t = pending_targets.pop_front();
                tgt.target_x     <= t.x;
                tgt.target_y     <= t.y;
                tgt.target_z     <= t.z;
                tgt.gripper_mode <= t.mode;
                tgt.valid        <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                tgt.valid <= 1'b0;
        end
    end

    // joint receiver stalls on a duty cycle that changes every so often
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jnt.ready   <= 1'b0;
            stall_duty  <= 100;
            stall_count <= 0;
        end
        else
        begin
            if (stall_count == 0)
            begin
                stall_count <= $urandom_range(50, 300);
                case ($urandom_range(0, 3))
                    0:       stall_duty <= 100;
                    1:       stall_duty <= 75;
                    2:       stall_duty <= 40;
                    default: stall_duty <= 10;
                endcase
            end
            else
                stall_count <= stall_count - 1;
            jnt.ready <= ($urandom_range(1, 100) <= stall_duty);
        end
    end

    // accepted requests, register writes and joint results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_UPPER)
                    upper_len <= cfg.data;
                else if (cfg.index == REG_LOWER)
                    lower_len <= cfg.data;
            end
            if (tgt.valid && tgt.ready)
                expected_joints.insert(expected_joints.size(),
                                       solve_joints(mk(tgt.target_x, tgt.target_y,
                                                       tgt.target_z, tgt.gripper_mode)));
            if (jnt.valid && jnt.ready)
            begin
                if (expected_joints.size() == 0)
                    report("unexpected result", 1, 0);
                else
                begin
                    joints_t e;
                    e = expected_joints.pop_front();
                    if (jnt.base_angle !== e.base)
                        report("base_angle", jnt.base_angle, e.base);
                    if (jnt.shoulder_angle !== e.shoulder)
                        report("shoulder_angle", jnt.shoulder_angle, e.shoulder);
                    if (jnt.elbow_angle !== e.elbow)
                        report("elbow_angle", jnt.elbow_angle, e.elbow);
                    if (jnt.wrist_pitch !== e.pitch)
                        report("wrist_pitch", jnt.wrist_pitch, e.pitch);
                    if (jnt.wrist_rotate !== e.rotate)
                        report("wrist_rotate", jnt.wrist_rotate, e.rotate);
                    if (jnt.wrist_valid !== e.wvalid)
                        report("wrist_valid", jnt.wrist_valid, e.wvalid);
                    if (jnt.out_of_reach !== e.oor)
                        report("out_of_reach", jnt.out_of_reach, e.oor);
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(negedge clk);
        while (!cfg.ready)
            @(negedge clk);
        @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_targets.size() == 0 && !tgt.valid && expected_joints.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] l1, input logic [LEN_W-1:0] l2,
                             input int count);
        write_reg(REG_UPPER, l1);
        write_reg(REG_LOWER, l2);
        @(posedge clk);
        for (int i = 0; i < count; i++)
            queue_target(random_target());
        drain();
    endtask

    // stimulus
    initial
    begin
        cfg.valid  = 1'b0;
        cfg.index  = '0;
        cfg.data   = '0;
        rst_n      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset lengths, origin, field extremes, every pose
        queue_target(mk(0, 0, 0, GRIP_DOWN));
        queue_target(mk(10000, 10000, 5000, GRIP_NONE));
        queue_target(mk(10000, 10000, 5000, GRIP_DOWN));
        queue_target(mk(10000, 10000, 5000, GRIP_LEVEL));
        queue_target(mk(10000, 10000, 5000, GRIP_SPARE));
        queue_target(mk(-12000, 3000, -4000, GRIP_DOWN));
        queue_target(mk(0, -15000, 0, GRIP_LEVEL));
        queue_target(mk(-9000, -9000, 9000, GRIP_DOWN));
        queue_target(mk(0, 0, 20000, GRIP_LEVEL));
        queue_target(mk(28836, 0, 0, GRIP_DOWN));
        queue_target(mk(40000, 0, 0, GRIP_LEVEL));
        queue_target(mk(100, 200, 50, GRIP_DOWN));
        queue_target(mk(131071, 131071, 131071, GRIP_SPARE));
        queue_target(mk(-131072, -131072, -131072, GRIP_NONE));
        queue_target(mk(1310, 0, 0, GRIP_DOWN));
        drain();

        // spare register indexes are ignored
        write_reg(REG_SPARE_A, 16'd7);
        write_reg(REG_SPARE_B, 16'd9);
        queue_target(mk(12000, -8000, 3000, GRIP_DOWN));
        drain();

        // length extremes, both links at their maximum
        write_reg(REG_UPPER, 16'd65535);
        write_reg(REG_LOWER, 16'd65535);
        queue_target(mk(131071, 131071, 131071, GRIP_DOWN));
        queue_target(mk(-131072, 0, -131072, GRIP_LEVEL));
        queue_target(mk(-131072, -131072, 0, GRIP_DOWN));
        drain();

        run_phase(UPPER_RESET, LOWER_RESET, 180);
        run_phase(16'd1, 16'd1, 30);
        run_phase(16'd0, 16'd15073, 40);
        run_phase(16'd65535, 16'd65535, 120);
        run_phase(16'd65535, 16'd1, 60);
        for (int p = 0; p < 5; p++)
            run_phase(LEN_W'($urandom_range(1, 65535)), LEN_W'($urandom_range(1, 65535)), 40);

        if (mismatches == 0)
            $display("** arm_inverse_kinematics_core: PASSED **");
        else
            $display("** arm_inverse_kinematics_core: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #3000000;
        $display("** arm_inverse_kinematics_core: FAILED **");
        $finish;
    end

endmodule
